// File: src/adtlv_pkg.sv
// ----------------------------------------------------------------------------
// adtlv_pkg
// Shared types and constants for the advertising-data segment parser.
// ----------------------------------------------------------------------------
package adtlv_pkg;

	localparam int unsigned MaxBufferBytes = 255;

	// Parse phases of the segment walker.
	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_TYPE    = 2'd1,
		PH_DATA    = 2'd2,
		PH_STOPPED = 2'd3
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Stop status codes.
	localparam logic [1:0] STAT_CONSUMED = 2'd0;
	localparam logic [1:0] STAT_ZERO_LEN = 2'd1;
	localparam logic [1:0] STAT_OVERRUN  = 2'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       start_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [6:0] segment_index;
		logic [7:0] segment_type;
		logic [7:0] data_length;
		logic [7:0] data_offset;
		logic [7:0] data_byte;
		logic       last_in_segment;
		logic [6:0] segment_count;
		logic [1:0] stop_status;
		logic       last_of_run;
	} out_item_t;

endpackage

// File: src/adtlv_in_if.sv
// ----------------------------------------------------------------------------
// adtlv_in_if
// Valid/ready channel carrying one payload byte item.
// ----------------------------------------------------------------------------
interface adtlv_in_if import adtlv_pkg::*; ;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/adtlv_out_if.sv
// ----------------------------------------------------------------------------
// adtlv_out_if
// Valid/ready channel carrying one parser result item.
// ----------------------------------------------------------------------------
interface adtlv_out_if import adtlv_pkg::*; ;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/ad_structure_tlv_parser_top.sv
// ----------------------------------------------------------------------------
// ad_structure_tlv_parser_top
// Streaming parser of advertising-data segments (length, type, data).
// ----------------------------------------------------------------------------
// A result item is registered and presented in the cycle after the byte item
// that causes it is accepted. One byte item per cycle while each byte yields
// at most one result and the output takes it; a byte that yields a result plus
// the summary holds the input until the first of its two results leaves the buffer.
// Reset: arst_n clears all parse state and the result buffer count at once and
// sets the buffer length register to 31; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ad_structure_tlv_parser_top import adtlv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	adtlv_in_if.sink           bytes,
	adtlv_out_if.source        results
);

	// Configuration register holding the buffer length in bytes.
	logic [7:0] buffer_length_q;

	// Parse state, updated only when a byte item is accepted.
	logic [7:0] byte_position_q;
	phase_t     parse_phase_q;
	logic [7:0] bytes_left_q;
	logic [7:0] current_type_q;
	logic [7:0] current_dlen_q;
	logic [6:0] segments_done_q;
	logic [1:0] stop_reason_q;

	// Next-state values computed from the incoming byte.
	logic [7:0] pos_n;
	phase_t     phase_n;
	logic [7:0] left_n;
	logic [7:0] type_n;
	logic [7:0] dlen_n;
	logic [6:0] segs_n;
	logic [1:0] stop_n;

	// Results produced by the incoming byte.
	out_item_t  main_res;
	out_item_t  sum_res;
	logic       main_v;
	logic       sum_v;

	// Two-entry result buffer: entry 0 is shown on the output.
	out_item_t  res0_q;
	out_item_t  res1_q;
	logic [1:0] res_cnt_q;

	logic       in_acc;
	logic       out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= 8'd31;
		end else if (cfg_we) begin
			buffer_length_q <= cfg_wdata;
		end
	end

	// Next-state and result logic. A start flag restarts the parse state before
	// the byte is looked at, exactly as if the buffer had begun afresh.
	always_comb begin
		logic [7:0] len_eff;
		logic [7:0] pos;
		phase_t     phase;
		logic [7:0] left;
		logic [7:0] ctype;
		logic [7:0] cdl;
		logic [6:0] segs;
		logic [1:0] stop;
		logic [8:0] reach;
		logic [7:0] b;

		b       = bytes.data.byte_value;
		// A zero length is taken as one byte; eight bits cannot exceed the maximum.
		len_eff = (buffer_length_q == 8'd0) ? 8'd1 : buffer_length_q;

		if (bytes.data.start_of_buffer) begin
			pos   = '0;
			phase = PH_LENGTH;
			left  = '0;
			ctype = '0;
			cdl   = '0;
			segs  = '0;
			stop  = '0;
		end else begin
			pos   = byte_position_q;
			phase = parse_phase_q;
			left  = bytes_left_q;
			ctype = current_type_q;
			cdl   = current_dlen_q;
			segs  = segments_done_q;
			stop  = stop_reason_q;
		end

		pos_n    = pos;
		phase_n  = phase;
		left_n   = left;
		type_n   = ctype;
		dlen_n   = cdl;
		segs_n   = segs;
		stop_n   = stop;
		main_v   = 1'b0;
		sum_v    = 1'b0;
		main_res = '0;
		sum_res  = '0;
		reach    = {1'b0, pos} + {1'b0, b};

		// Bytes past the end of the buffer are dropped without any result.
		if (pos < len_eff) begin
			case (phase)
				PH_LENGTH: begin
					if (b == 8'd0) begin
						stop_n  = STAT_ZERO_LEN;
						phase_n = PH_STOPPED;
					end else if (reach >= {1'b0, len_eff}) begin
						// The segment and its length byte would not fit.
						stop_n  = STAT_OVERRUN;
						phase_n = PH_STOPPED;
					end else begin
						dlen_n  = b - 8'd1;
						phase_n = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_n                   = b;
					main_v                   = 1'b1;
					main_res.result_kind     = KIND_HEADER;
					main_res.segment_index   = segs;
					main_res.segment_type    = b;
					main_res.data_length     = cdl;
					main_res.last_in_segment = (cdl == 8'd0);
					if (cdl == 8'd0) begin
						segs_n  = segs + 7'd1;
						phase_n = PH_LENGTH;
					end else begin
						left_n  = cdl;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					left_n                   = left - 8'd1;
					main_v                   = 1'b1;
					main_res.result_kind     = KIND_DATA;
					main_res.segment_index   = segs;
					main_res.segment_type    = ctype;
					main_res.data_length     = cdl;
					main_res.data_offset     = cdl - left;
					main_res.data_byte       = b;
					main_res.last_in_segment = (left_n == 8'd0);
					if (left_n == 8'd0) begin
						segs_n  = segs + 7'd1;
						phase_n = PH_LENGTH;
					end
				end
				default: begin
				end
			endcase

			// The position stays below the length, so the increment cannot wrap.
			pos_n = pos + 8'd1;
			if (pos_n == len_eff) begin
				sum_v                 = 1'b1;
				sum_res.result_kind   = KIND_SUMMARY;
				sum_res.segment_count = segs_n;
				case (phase_n)
					PH_STOPPED: sum_res.stop_status = stop_n;
					PH_LENGTH:  sum_res.stop_status = STAT_CONSUMED;
					default:    sum_res.stop_status = STAT_OVERRUN;
				endcase
				sum_res.last_of_run = 1'b1;
			end
		end

		main_res.last_of_run = !sum_v;
	end

	// The input is taken only when the result buffer will be empty after this
	// cycle, so both results of one byte always find room.
	assign bytes.ready   = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && results.ready);
	assign in_acc        = bytes.valid && bytes.ready;
	assign out_pop       = results.valid && results.ready;
	assign results.valid = (res_cnt_q != 2'd0);
	assign results.data  = res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			parse_phase_q   <= PH_LENGTH;
			bytes_left_q    <= '0;
			current_type_q  <= '0;
			current_dlen_q  <= '0;
			segments_done_q <= '0;
			stop_reason_q   <= '0;
		end else if (in_acc) begin
			byte_position_q <= pos_n;
			parse_phase_q   <= phase_n;
			bytes_left_q    <= left_n;
			current_type_q  <= type_n;
			current_dlen_q  <= dlen_n;
			segments_done_q <= segs_n;
			stop_reason_q   <= stop_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (in_acc) begin
			res_cnt_q <= {1'b0, main_v} + {1'b0, sum_v};
		end else if (out_pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// Result payload carries no reset; only the count qualifies it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res0_q <= main_v ? main_res : sum_res;
			res1_q <= sum_res;
		end else if (out_pop) begin
			res0_q <= res1_q;
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the advertising-data segment parser. Byte items are
// pushed through the input channel while a cycle-free model of the segment
// walker predicts every header, data and summary item. A checker compares each
// result item with the oldest prediction, field by field. Both channels idle
// and stall at random, and the buffer length is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import adtlv_pkg::*;

	// A quiet stretch longer than this means the block has hung. It has to
	// cover the long result hold-off below plus the longest random gaps.
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	localparam int PHASE_BUDGET  = 240;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	adtlv_in_if  byte_ch ();
	adtlv_out_if result_ch ();

	ad_structure_tlv_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bytes     (byte_ch),
		.results   (result_ch)
	);

	// Idling controls, changed from phase to phase by the random test.
	bit src_gaps    = 1'b1;
	bit sink_stalls = 1'b1;
	int hold_cycles = 0;

	int unsigned mismatches = 0;

	// Result items still to arrive, oldest first.
	out_item_t pending_results[$];

	// Our own copy of the register and of the segment walker state.
	logic [7:0] buf_len    = 8'd31;
	phase_t     walk_phase = PH_LENGTH;
	logic [7:0] walk_pos   = '0;
	logic [7:0] seg_left   = '0;
	logic [7:0] seg_type   = '0;
	logic [7:0] seg_dlen   = '0;
	logic [6:0] segs_done  = '0;
	logic [1:0] stop_code  = STAT_CONSUMED;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Segment walker model: works out the result items caused by one accepted
	// byte item and queues them. A byte yields at most one header or data item
	// plus, when it is the last byte of the buffer, the summary item.
	// ------------------------------------------------------------------------
	function automatic void parse_byte_expect(input logic [7:0] value, input logic sob);
		out_item_t found[2];
		int        n;
		logic [7:0] limit;
		logic [8:0] reach;
		n = 0;
		found[0] = '0;
		found[1] = '0;
		// A zero length register behaves as a one-byte buffer.
		limit = (buf_len == 8'd0) ? 8'd1 : buf_len;
		if (sob) begin
			walk_pos   = '0;
			walk_phase = PH_LENGTH;
			seg_left   = '0;
			seg_type   = '0;
			seg_dlen   = '0;
			segs_done  = '0;
			stop_code  = STAT_CONSUMED;
		end
		// Past the end of the buffer nothing happens until the next start flag.
		if (walk_pos >= limit)
			return;
		case (walk_phase)
			PH_LENGTH: begin
				reach = {1'b0, walk_pos} + {1'b0, value};
				if (value == 8'd0) begin
					stop_code  = STAT_ZERO_LEN;
					walk_phase = PH_STOPPED;
				end else if (reach >= {1'b0, limit}) begin
					// The length byte plus its segment would not fit.
					stop_code  = STAT_OVERRUN;
					walk_phase = PH_STOPPED;
				end else begin
					seg_dlen   = value - 8'd1;
					walk_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				seg_type = value;
				found[n].result_kind     = KIND_HEADER;
				found[n].segment_index   = segs_done;
				found[n].segment_type    = value;
				found[n].data_length     = seg_dlen;
				found[n].last_in_segment = (seg_dlen == 8'd0);
				n++;
				if (seg_dlen == 8'd0) begin
					segs_done++;
					walk_phase = PH_LENGTH;
				end else begin
					seg_left   = seg_dlen;
					walk_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				found[n].result_kind   = KIND_DATA;
				found[n].segment_index = segs_done;
				found[n].segment_type  = seg_type;
				found[n].data_length   = seg_dlen;
				found[n].data_offset   = seg_dlen - seg_left;
				found[n].data_byte     = value;
				seg_left--;
				found[n].last_in_segment = (seg_left == 8'd0);
				n++;
				if (seg_left == 8'd0) begin
					segs_done++;
					walk_phase = PH_LENGTH;
				end
			end
			default: ;
		endcase
		walk_pos++;
		if (walk_pos == limit) begin
			found[n].result_kind   = KIND_SUMMARY;
			found[n].segment_count = segs_done;
			if (walk_phase == PH_STOPPED)
				found[n].stop_status = stop_code;
			else if (walk_phase == PH_LENGTH)
				found[n].stop_status = STAT_CONSUMED;
			else
				found[n].stop_status = STAT_OVERRUN;
			n++;
		end
		if (n > 0)
			found[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(found[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Offers one byte item, with an occasional random gap in front of it, and
	// returns at the edge that accepts it. Valid stays high afterwards so that
	// back-to-back items go out without a bubble.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] value, input logic sob);
		in_item_t item;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item.byte_value      = value;
		item.start_of_buffer = sob;
		byte_ch.valid <= 1'b1;
		byte_ch.data  <= item;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		parse_byte_expect(value, sob);
	endtask

	// ------------------------------------------------------------------------
	// Register write. The input is stopped and every outstanding result item
	// is collected first; a length byte gives no result, so the bench also waits
	// for the registered parse state to settle.
	// ------------------------------------------------------------------------
	task automatic write_buffer_length(input logic [7:0] value);
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		buf_len  = value;
	endtask

	// Straight after reset with no start flag: the first byte opens a buffer.
	// One full segment, a zero length stop, ignored bytes, then a byte past the
	// buffer end which must give nothing at all.
	task automatic test_first_bytes_without_start();
		write_buffer_length(8'd6);
		send_byte(8'd2, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	// An empty segment (header only), then a length that runs past the end.
	task automatic test_zero_and_overrun_stops();
		write_buffer_length(8'd4);
		send_byte(8'd1, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'd5, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// A zero length register (one-byte buffers), and a three-byte buffer whose
	// last data byte also carries the summary, so two results from one byte.
	task automatic test_short_buffer_lengths();
		write_buffer_length(8'd0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h00, 1'b1);
		write_buffer_length(8'd3);
		send_byte(8'd2, 1'b1);
		send_byte(8'h42, 1'b0);
		send_byte(8'h99, 1'b0);
	endtask

	// The length is cut below the current position mid-buffer, so the next
	// byte is dropped, then raised so that the buffer ends inside a segment.
	task automatic test_length_change_mid_buffer();
		write_buffer_length(8'd20);
		send_byte(8'd3, 1'b1);
		send_byte(8'h10, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hBB, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'h20, 1'b0);
		write_buffer_length(8'd5);
		send_byte(8'h44, 1'b0);
		write_buffer_length(8'd7);
		send_byte(8'h55, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// One buffer of random shape. Most buffers are proper segment chains with
	// random types and data; some are broken on purpose by a zero length or an
	// overrunning length part-way through, and some are plain noise with stray
	// start flags. Now and then a few bytes trail the end of the buffer.
	// ------------------------------------------------------------------------
	task automatic send_random_buffer(input int unsigned size, output int unsigned sent);
		int unsigned pos;
		int unsigned remaining;
		int unsigned seg_len;
		int unsigned style;
		int unsigned break_at;
		logic        first;
		style    = $urandom_range(0, 9);
		break_at = $urandom_range(0, size - 1);
		pos      = 0;
		first    = 1'b1;
		while (pos < size) begin
			remaining = size - pos;
			if (style == 9) begin
				send_byte(8'($urandom_range(0, 255)), first || ($urandom_range(0, 19) == 0));
				pos++;
			end else begin
				if (style >= 7 && pos >= break_at)
					seg_len = (style == 7) ? 0 : $urandom_range(remaining, 255);
				else if (remaining == 1)
					seg_len = $urandom_range(0, 1);
				else if ($urandom_range(0, 4) == 0)
					seg_len = remaining - 1;
				else
					seg_len = $urandom_range(1, (remaining - 1 < 10) ? remaining - 1 : 10);
				send_byte(8'(seg_len), first);
				pos++;
				if (seg_len == 0 || seg_len >= remaining) begin
					// Parsing has stopped; the rest of the buffer is ignored.
					while (pos < size) begin
						send_byte(8'($urandom_range(0, 255)), 1'b0);
						pos++;
					end
				end else begin
					send_byte(8'($urandom_range(0, 255)), 1'b0);
					pos++;
					repeat (seg_len - 1) begin
						send_byte(8'($urandom_range(0, 255)), 1'b0);
						pos++;
					end
				end
			end
			first = 1'b0;
		end
		sent = pos;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0);
				sent++;
			end
		end
	endtask

	// Phases at several buffer lengths, the extremes among them. The phase at
	// 64 bytes starts with a long result hold-off so that the block backs up
	// and stalls its input; the final phase runs without any idling.
	task automatic test_random_buffers();
		logic [7:0]  lengths[8] = '{8'd255, 8'd1, 8'd31, 8'd12, 8'd64, 8'd2, 8'd7, 8'd40};
		int unsigned phase_bytes;
		int unsigned sent;
		foreach (lengths[p]) begin
			write_buffer_length(lengths[p]);
			src_gaps    = (p != 7) && ($urandom_range(0, 3) != 0);
			sink_stalls = (p != 7) && ($urandom_range(0, 3) != 0);
			if (lengths[p] == 8'd64)
				hold_cycles = LONG_HOLD;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BUDGET) begin
				send_random_buffer(32'(lengths[p]), sent);
				phase_bytes += sent;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: ready drops in random bursts, or for one long hold-off when
	// a test asks for it. Its length is taken from hold_cycles, which is then cleared.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int n;
		result_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Every accepted result item is held against the oldest prediction.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result item with none expected, expected none, actual kind %0d",
					$time, result_ch.data.result_kind);
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 32'(want.result_kind),
					32'(result_ch.data.result_kind));
				check_field("segment_index", 32'(want.segment_index),
					32'(result_ch.data.segment_index));
				check_field("segment_type", 32'(want.segment_type),
					32'(result_ch.data.segment_type));
				check_field("data_length", 32'(want.data_length),
					32'(result_ch.data.data_length));
				check_field("data_offset", 32'(want.data_offset),
					32'(result_ch.data.data_offset));
				check_field("data_byte", 32'(want.data_byte),
					32'(result_ch.data.data_byte));
				check_field("last_in_segment", 32'(want.last_in_segment),
					32'(result_ch.data.last_in_segment));
				check_field("segment_count", 32'(want.segment_count),
					32'(result_ch.data.segment_count));
				check_field("stop_status", 32'(want.stop_status),
					32'(result_ch.data.stop_status));
				check_field("last_of_run", 32'(want.last_of_run),
					32'(result_ch.data.last_of_run));
			end
		end
	end

	// Watchdog: ends the run if no item moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Main sequence: one reset, the directed checks, then the random buffers,
	// and finally a drain until every predicted result item has arrived.
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_bytes_without_start();
		test_zero_and_overrun_stops();
		test_short_buffer_lengths();
		test_length_change_mid_buffer();
		test_random_buffers();

		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
